[hdl/asrp_pkg.sv]
// Shared types, constants and codes for the adaptive sample-rate pacer.
package asrp_pkg;

  // Timing constants
  localparam logic [15:0] TICKS_PER_MINUTE   = 16'd61440;
  localparam logic [15:0] RETRY_THRESHOLD    = 16'd128;
  localparam logic [15:0] RETRY_TICKS        = 16'd16;
  localparam logic [15:0] DEFAULT_RATE       = 16'd60;
  localparam logic [31:0] SECONDS_PER_MINUTE = 32'd60;
  localparam logic [15:0] SPACE_NO_RATE      = 16'hFFFF;

  // Reciprocal of 60 for a 32-bit span: span / 60 = (span * RECIP_MINUTE) >> RECIP_MINUTE_SHIFT
  localparam logic [31:0] RECIP_MINUTE       = 32'h88888889;
  localparam int          RECIP_MINUTE_SHIFT = 37;

  // Iterative divider geometry
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSORS_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPACE       = 2'd3;
  localparam logic [15:0] MAX_RATE_RST  = 16'd240;
  localparam logic [15:0] MIN_SPACE_RST = 16'd16;
  localparam logic [15:0] MAX_SPACE_RST = 16'd61440;

  // Command modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] requested_rate;
    logic [31:0] now_seconds;
    logic        buffer_ready;
  } in_t;

  typedef struct packed {
    logic        ack_code;
    logic        sample_due;
    logic [15:0] sample_number;
    logic [15:0] current_space;
    logic        active;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START_DIV,
    ST_GOAL,
    ST_PROD,
    ST_RES_GO,
    ST_RES_DIV,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_SEL_START,
    DIV_SEL_RESCALE
  } div_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     set_ack;
    logic     start_setup;
    logic     set_start_space;
    logic     stop;
    logic     div_go;
    div_sel_t div_sel;
    logic     mul_min;
    logic     mul_goal;
    logic     mul_prod;
    logic     rescale_zero;
    logic     rescale_clamp;
    logic     count_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       sensors;
    logic       running;
    logic       boundary_hit;
    logic       rate_zero;
    logic       taken_zero;
    logic       div_busy;
    logic       div_done;
  } status_t;

endpackage

[hdl/asrp_div.sv]
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module asrp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [asrp_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [asrp_pkg::DIVISOR_W-1:0]      divisor,
  output logic [asrp_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                                busy,
  output logic                                done
);

  logic [asrp_pkg::DIVIDEND_W-1:0] quo;
  logic [asrp_pkg::DIVISOR_W-1:0]  rem;
  logic [asrp_pkg::DIVISOR_W-1:0]  dvs;
  logic [asrp_pkg::DIV_CNT_W-1:0]  cnt;
  logic [asrp_pkg::DIVISOR_W:0]    shifted;
  logic [asrp_pkg::DIVISOR_W:0]    sub;
  logic                            ge;
  logic [asrp_pkg::DIVISOR_W-1:0]  rem_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted  = {rem, quo[asrp_pkg::DIVIDEND_W-1]};
    sub      = shifted - {1'b0, dvs};
    ge       = (shifted >= {1'b0, dvs});
    rem_next = ge ? sub[asrp_pkg::DIVISOR_W-1:0] : shifted[asrp_pkg::DIVISOR_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == asrp_pkg::DIV_CNT_W'(asrp_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[asrp_pkg::DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

[hdl/asrp_dp.sv]
// Datapath: configuration, pacing state, multipliers, divider and result word.
module asrp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  asrp_pkg::cmd_t                    cmd,
  output asrp_pkg::status_t                 status,
  input  asrp_pkg::in_t                     in_data,
  input  logic                              cfg_we,
  input  logic [asrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data,
  output asrp_pkg::out_t                    out_data
);

  // Configuration
  logic        sensors_present;
  logic [15:0] max_rate;
  logic [15:0] min_space;
  logic [15:0] max_space;

  // Pacing state
  logic        running;
  logic [15:0] target_rate;
  logic [15:0] spacing;
  logic [15:0] countdown;
  logic [31:0] taken_count;
  logic [31:0] start_second;
  logic [31:0] next_boundary;

  // Per-word working registers
  asrp_pkg::in_t item;
  logic          ack;
  logic          due;
  logic [15:0]   number;
  logic [31:0]   minutes;
  logic [47:0]   goal;
  logic [63:0]   prod;

  logic [15:0] rate_base;
  logic [15:0] rate_eff;
  logic [31:0] minute_span;
  logic [63:0] min_mul;
  logic [47:0] goal_mul;
  logic [63:0] prod_mul;
  logic [15:0] clamped;
  logic        q_over;

  logic [asrp_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [asrp_pkg::DIVISOR_W-1:0]  div_divisor;
  logic [asrp_pkg::DIVIDEND_W-1:0] div_q;
  logic                            div_busy;
  logic                            div_done;

  // Rate select, minute span, products and clamp
  always_comb begin
    rate_base   = (item.requested_rate == 16'd0) ? asrp_pkg::DEFAULT_RATE
                                                 : item.requested_rate;
    rate_eff    = (rate_base > max_rate) ? max_rate : rate_base;
    minute_span = next_boundary - start_second;
    min_mul     = {32'd0, minute_span} * {32'd0, asrp_pkg::RECIP_MINUTE};
    goal_mul    = {16'd0, minutes} * {32'd0, target_rate};
    prod_mul    = {48'd0, spacing} * {16'd0, goal};
    q_over      = (|div_q[asrp_pkg::DIVIDEND_W-1:16]) || (div_q[15:0] > max_space);
    if (q_over) begin
      clamped = max_space;
    end else if (div_q[15:0] < min_space) begin
      clamped = min_space;
    end else begin
      clamped = div_q[15:0];
    end
  end

  // Divider operand select
  always_comb begin
    unique case (cmd.div_sel)
      asrp_pkg::DIV_SEL_START: begin
        div_dividend = asrp_pkg::DIVIDEND_W'(asrp_pkg::TICKS_PER_MINUTE);
        div_divisor  = asrp_pkg::DIVISOR_W'(rate_eff);
      end
      asrp_pkg::DIV_SEL_RESCALE: begin
        div_dividend = prod;
        div_divisor  = taken_count;
      end
      default: begin
        div_dividend = prod;
        div_divisor  = taken_count;
      end
    endcase
  end

  asrp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  // Configuration and pacing state
  always_ff @(posedge clk) begin
    if (rst) begin
      sensors_present <= 1'b0;
      max_rate        <= asrp_pkg::MAX_RATE_RST;
      min_space       <= asrp_pkg::MIN_SPACE_RST;
      max_space       <= asrp_pkg::MAX_SPACE_RST;
      running         <= 1'b0;
      target_rate     <= '0;
      spacing         <= '0;
      countdown       <= '0;
      taken_count     <= '0;
      start_second    <= '0;
      next_boundary   <= '0;
      ack             <= 1'b0;
      due             <= 1'b0;
      number          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          asrp_pkg::CFG_SENSORS_PRESENT: sensors_present <= cfg_data[0];
          asrp_pkg::CFG_MAX_RATE:        max_rate        <= cfg_data;
          asrp_pkg::CFG_MIN_SPACE:       min_space       <= cfg_data;
          asrp_pkg::CFG_MAX_SPACE:       max_space       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_item) begin
        ack    <= 1'b0;
        due    <= 1'b0;
        number <= '0;
      end
      if (cmd.set_ack) begin
        ack <= 1'b1;
      end
      // Arm sampling; a zero rate limit gives the widest spacing
      if (cmd.start_setup) begin
        target_rate   <= rate_eff;
        taken_count   <= '0;
        start_second  <= item.now_seconds;
        next_boundary <= item.now_seconds + asrp_pkg::SECONDS_PER_MINUTE;
        running       <= 1'b1;
        if (rate_eff == 16'd0) begin
          spacing   <= asrp_pkg::SPACE_NO_RATE;
          countdown <= asrp_pkg::SPACE_NO_RATE;
        end
      end
      if (cmd.set_start_space) begin
        spacing   <= div_q[15:0];
        countdown <= div_q[15:0];
      end
      // Stop keeps the spacing
      if (cmd.stop) begin
        running      <= 1'b0;
        target_rate  <= '0;
        taken_count  <= '0;
        start_second <= '0;
        countdown    <= '0;
      end
      if (cmd.rescale_zero) begin
        spacing       <= min_space;
        next_boundary <= next_boundary + asrp_pkg::SECONDS_PER_MINUTE;
      end
      if (cmd.rescale_clamp) begin
        spacing       <= clamped;
        next_boundary <= next_boundary + asrp_pkg::SECONDS_PER_MINUTE;
      end
      // Count down; on expiry issue, retry or skip
      if (cmd.count_step) begin
        if (countdown <= 16'd1) begin
          if (item.buffer_ready) begin
            due         <= 1'b1;
            number      <= taken_count[15:0];
            taken_count <= taken_count + 32'd1;
            countdown   <= spacing;
          end else if (spacing > asrp_pkg::RETRY_THRESHOLD) begin
            countdown <= asrp_pkg::RETRY_TICKS;
          end else begin
            countdown <= spacing;
          end
        end else begin
          countdown <= countdown - 16'd1;
        end
      end
    end
  end

  // Item capture, products and result word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.mul_min) begin
      minutes <= 32'(min_mul >> asrp_pkg::RECIP_MINUTE_SHIFT);
    end
    if (cmd.mul_goal) begin
      goal <= goal_mul;
    end
    if (cmd.mul_prod) begin
      prod <= prod_mul;
    end
    if (cmd.load_out) begin
      out_data.ack_code      <= ack;
      out_data.sample_due    <= due;
      out_data.sample_number <= number;
      out_data.current_space <= spacing;
      out_data.active        <= running;
    end
  end

  assign status.mode         = item.mode;
  assign status.sensors      = sensors_present;
  assign status.running      = running;
  assign status.boundary_hit = (item.now_seconds >= next_boundary);
  assign status.rate_zero    = (rate_eff == 16'd0);
  assign status.taken_zero   = (taken_count == 32'd0);
  assign status.div_busy     = div_busy;
  assign status.div_done     = div_done;

endmodule

[hdl/asrp_ctrl.sv]
// Controller: sequences one word through decode, divisions, products and count.
module asrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  asrp_pkg::status_t status,
  output asrp_pkg::cmd_t    cmd
);

  asrp_pkg::state_t state;
  asrp_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asrp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word flag: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = asrp_pkg::DIV_SEL_START;
    in_ready    = 1'b0;
    unique case (state)
      asrp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = asrp_pkg::ST_DECODE;
        end
      end
      asrp_pkg::ST_DECODE: begin
        priority if (status.mode == asrp_pkg::MODE_START) begin
          if (!status.sensors) begin
            cmd.set_ack = 1'b1;
            state_next  = asrp_pkg::ST_DONE;
          end else begin
            cmd.start_setup = 1'b1;
            if (status.rate_zero) begin
              state_next = asrp_pkg::ST_DONE;
            end else begin
              cmd.div_go  = 1'b1;
              cmd.div_sel = asrp_pkg::DIV_SEL_START;
              state_next  = asrp_pkg::ST_START_DIV;
            end
          end
        end else if (status.mode == asrp_pkg::MODE_STOP) begin
          cmd.stop   = 1'b1;
          state_next = asrp_pkg::ST_DONE;
        end else if (status.mode == asrp_pkg::MODE_TICK && status.running) begin
          if (status.boundary_hit) begin
            cmd.mul_min = 1'b1;
            state_next  = asrp_pkg::ST_GOAL;
          end else begin
            state_next = asrp_pkg::ST_COUNT;
          end
        end else begin
          state_next = asrp_pkg::ST_DONE;
        end
      end
      asrp_pkg::ST_START_DIV: begin
        if (status.div_done) begin
          cmd.set_start_space = 1'b1;
          state_next          = asrp_pkg::ST_DONE;
        end
      end
      asrp_pkg::ST_GOAL: begin
        cmd.mul_goal = 1'b1;
        state_next   = asrp_pkg::ST_PROD;
      end
      asrp_pkg::ST_PROD: begin
        if (status.taken_zero) begin
          cmd.rescale_zero = 1'b1;
          state_next       = asrp_pkg::ST_COUNT;
        end else begin
          cmd.mul_prod = 1'b1;
          state_next   = asrp_pkg::ST_RES_GO;
        end
      end
      asrp_pkg::ST_RES_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = asrp_pkg::DIV_SEL_RESCALE;
        state_next  = asrp_pkg::ST_RES_DIV;
      end
      asrp_pkg::ST_RES_DIV: begin
        cmd.div_sel = asrp_pkg::DIV_SEL_RESCALE;
        if (status.div_done) begin
          cmd.rescale_clamp = 1'b1;
          state_next        = asrp_pkg::ST_COUNT;
        end
      end
      asrp_pkg::ST_COUNT: begin
        cmd.count_step = 1'b1;
        state_next     = asrp_pkg::ST_DONE;
      end
      asrp_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = asrp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = asrp_pkg::ST_IDLE;
      end
    endcase
  end

  // Never overwrite a result word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result word overwritten while pending");

  // Divider is quiet whenever no word is in progress
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == asrp_pkg::ST_IDLE) |-> !status.div_busy)
    else $error("divider busy while controller idle");

  // A launch is only issued to an idle divider
  a_div_launch: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !status.div_busy)
    else $error("divider relaunched while busy");

  // A divider completion only arrives while a division is awaited
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == asrp_pkg::ST_START_DIV ||
                         state == asrp_pkg::ST_RES_DIV))
    else $error("divider result with no division pending");

endmodule

[hdl/adaptive_sample_rate_pacer.sv]
// Top level of the adaptive sample-rate pacer: controller plus datapath.
//
//   channel   signals                          direction  word
//   in        in_valid / in_ready / in_data    input      mode, rate, seconds, buffer
//   out       out_valid / out_ready / out_data output     ack, sample, spacing, active
//   cfg       cfg_we / cfg_index / cfg_data    input      register write, no wait
//
// One word at a time. Stop, idle tick, ignored mode and refused or zero-rate start
// go from accept through decode straight to the result; a running tick adds a count
// step; a start adds one pass of the 64-step divider. A tick that crosses a minute
// boundary adds a reciprocal multiply for span / 60, two product stages and one divider
// pass (scaled spacing / samples taken); when no samples were taken, the second product
// and the divider pass are skipped. The next word is taken the cycle after the result is loaded.
// Reset is synchronous and clears configuration to defaults and all pacing state.
// A result waiting in the output register blocks only the next result, not
// the next accept; the controller holds in its final state until the slot frees.
module adaptive_sample_rate_pacer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  asrp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output asrp_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [asrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  asrp_pkg::cmd_t    cmd;
  asrp_pkg::status_t status;

  asrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  asrp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

[tb/asrp_checker.sv]
// Result checker for the pacer: follows both channels, predicts each word and compares.
module asrp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  asrp_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  asrp_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [asrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             errors,
  output int                             outstanding
);

  localparam int REPORT_LIMIT = 10;

  // Copies of the configuration registers
  logic        sensors_q;
  logic [15:0] rate_cap;
  logic [15:0] space_lo;
  logic [15:0] space_hi;

  // Pacing state as the block should hold it
  logic        run_q;
  logic [15:0] target_q;
  logic [15:0] space_q;
  logic [15:0] count_q;
  logic [31:0] taken_q;
  logic [31:0] origin_q;
  logic [31:0] boundary_q;

  asrp_pkg::out_t expected_words[$];
  int             word_index;

  // Advance the pacing state by one input word and form the word it answers with
  task automatic pace(input asrp_pkg::in_t w, output asrp_pkg::out_t r);
    logic [15:0] rate;
    logic [31:0] minutes;
    logic [63:0] goal;
    logic [63:0] scaled;
    r = '0;
    case (w.mode)
      asrp_pkg::MODE_START: begin
        if (!sensors_q) begin
          r.ack_code = 1'b1;
        end else begin
          rate = (w.requested_rate == 16'd0) ? asrp_pkg::DEFAULT_RATE : w.requested_rate;
          if (rate > rate_cap) rate = rate_cap;
          target_q   = rate;
          space_q    = (rate == 16'd0) ? asrp_pkg::SPACE_NO_RATE
                                       : asrp_pkg::TICKS_PER_MINUTE / rate;
          count_q    = space_q;
          taken_q    = '0;
          origin_q   = w.now_seconds;
          boundary_q = w.now_seconds + asrp_pkg::SECONDS_PER_MINUTE;
          run_q      = 1'b1;
        end
      end
      asrp_pkg::MODE_STOP: begin
        // Clear everything but the spacing and the next boundary
        run_q    = 1'b0;
        target_q = '0;
        taken_q  = '0;
        origin_q = '0;
        count_q  = '0;
      end
      asrp_pkg::MODE_TICK: begin
        if (run_q) begin
          // Rescale at a minute boundary before counting down
          if (w.now_seconds >= boundary_q) begin
            minutes = (boundary_q - origin_q) / asrp_pkg::SECONDS_PER_MINUTE;
            goal    = 64'(minutes) * 64'(target_q);
            if (taken_q == 32'd0) begin
              space_q = space_lo;
            end else begin
              scaled = (64'(space_q) * goal) / 64'(taken_q);
              if (scaled > 64'(space_hi)) space_q = space_hi;
              else if (scaled < 64'(space_lo)) space_q = space_lo;
              else space_q = scaled[15:0];
            end
            boundary_q = boundary_q + asrp_pkg::SECONDS_PER_MINUTE;
          end
          if (count_q <= 16'd1) begin
            if (w.buffer_ready) begin
              r.sample_due    = 1'b1;
              r.sample_number = taken_q[15:0];
              taken_q         = taken_q + 32'd1;
              count_q         = space_q;
            end else if (space_q > asrp_pkg::RETRY_THRESHOLD) begin
              count_q = asrp_pkg::RETRY_TICKS;
            end else begin
              count_q = space_q;
            end
          end else begin
            count_q = count_q - 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.current_space = space_q;
    r.active        = run_q;
  endtask

  always @(posedge clk) begin
    asrp_pkg::out_t want;
    asrp_pkg::out_t got;
    if (rst) begin
      sensors_q  = 1'b0;
      rate_cap   = asrp_pkg::MAX_RATE_RST;
      space_lo   = asrp_pkg::MIN_SPACE_RST;
      space_hi   = asrp_pkg::MAX_SPACE_RST;
      run_q      = 1'b0;
      target_q   = '0;
      space_q    = '0;
      count_q    = '0;
      taken_q    = '0;
      origin_q   = '0;
      boundary_q = '0;
      expected_words.delete();
      word_index = 0;
      errors     = 0;
      outstanding <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          asrp_pkg::CFG_SENSORS_PRESENT: sensors_q = cfg_data[0];
          asrp_pkg::CFG_MAX_RATE:        rate_cap  = cfg_data;
          asrp_pkg::CFG_MIN_SPACE:       space_lo  = cfg_data;
          asrp_pkg::CFG_MAX_SPACE:       space_hi  = cfg_data;
          default: ;
        endcase
      end

      // Compare a returned word with the oldest prediction
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_words.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("word %0d: unexpected: ack=%0d due=%0d num=%0d space=%0d active=%0d",
                     word_index, got.ack_code, got.sample_due, got.sample_number,
                     got.current_space, got.active);
          errors = errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (got.ack_code !== want.ack_code || got.sample_due !== want.sample_due ||
              got.sample_number !== want.sample_number ||
              got.current_space !== want.current_space || got.active !== want.active) begin
            if (errors < REPORT_LIMIT)
              $display({"word %0d: expected ack=%0d due=%0d num=%0d space=%0d active=%0d,",
                        " got ack=%0d due=%0d num=%0d space=%0d active=%0d"},
                       word_index, want.ack_code, want.sample_due, want.sample_number,
                       want.current_space, want.active, got.ack_code, got.sample_due,
                       got.sample_number, got.current_space, got.active);
            errors = errors + 1;
          end
        end
        word_index = word_index + 1;
      end

      // Predict the answer to an accepted word
      if (in_valid && in_ready) begin
        pace(in_data, want);
        expected_words.push_back(want);
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

[tb/adaptive_sample_rate_pacer_test.sv]
// Testbench top for the pacer: clock, reset, stimulus, stalls and the verdict.
module adaptive_sample_rate_pacer_test;

  // Mode value that the block ignores
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  asrp_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  asrp_pkg::out_t                 out_data;
  logic                           cfg_we = 1'b0;
  logic [asrp_pkg::CFG_IDX_W-1:0] cfg_index = asrp_pkg::CFG_SENSORS_PRESENT;
  logic [15:0]                    cfg_data = '0;
  int                             errors;
  int                             outstanding;

  bit          calm = 1'b0;     // no idling on either side
  bit          steady = 1'b0;   // phase without idling
  int          ready_hold = 0;
  int          words = 0;
  logic [31:0] clock_s = '0;    // seconds value carried through a session

  adaptive_sample_rate_pacer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  asrp_checker watch (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side in bursts, alternating with open stretches
  always @(posedge clk) begin
    if (calm || steady) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(1, 17);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(1, 48);
    end
  end

  // Offer one word, sometimes with a random gap ahead of it, and hold it until accepted
  task automatic send(input logic [1:0] mode, input logic [15:0] rate,
                      input logic [31:0] now, input logic ready);
    asrp_pkg::in_t w;
    w.mode           = mode;
    w.requested_rate = rate;
    w.now_seconds    = now;
    w.buffer_ready   = ready;
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words = words + 1;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic program_regs(input logic sensors, input logic [15:0] cap,
                              input logic [15:0] lo, input logic [15:0] hi);
    logic [14:0] junk;
    junk = 15'($urandom);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= asrp_pkg::CFG_SENSORS_PRESENT;
    cfg_data  <= {junk, sensors};
    @(posedge clk);
    cfg_index <= asrp_pkg::CFG_MAX_RATE;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= asrp_pkg::CFG_MIN_SPACE;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= asrp_pkg::CFG_MAX_SPACE;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One pacing session: a start, then ticks with advancing seconds and some noise
  task automatic session(input int n);
    logic [15:0] rate;
    int k;
    case ($urandom_range(0, 9))
      0:       rate = 16'd0;
      1:       rate = 16'($urandom);
      2:       rate = 16'($urandom_range(1, 400));
      default: rate = 16'($urandom_range(1024, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       clock_s = $urandom_range(32'hFFFFFF00, 32'hFFFFFFFF);
      1:       clock_s = $urandom;
      default: clock_s = clock_s + $urandom_range(0, 100);
    endcase
    send(asrp_pkg::MODE_START, rate, clock_s, 1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 39))
        0: send(asrp_pkg::MODE_STOP, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        1: send(MODE_IGNORED, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        2: send(asrp_pkg::MODE_START, 16'($urandom), clock_s, 1'($urandom_range(0, 1)));
        3: send(asrp_pkg::MODE_TICK, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        4: begin
          // jump one or more minutes ahead
          clock_s = clock_s + $urandom_range(60, 20000);
          send(asrp_pkg::MODE_TICK, 16'($urandom), clock_s, 1'($urandom_range(0, 1)));
        end
        default: begin
          clock_s = clock_s + $urandom_range(0, 4);
          send(asrp_pkg::MODE_TICK, 16'($urandom), clock_s, $urandom_range(0, 6) != 0);
        end
      endcase
    end
  endtask

  initial begin
    int phase;
    int quota;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No sensors: refused start, idle tick, stop, ignored mode
    send(asrp_pkg::MODE_START, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd0, 1'b1);
    send(asrp_pkg::MODE_STOP, 16'd0, 32'd0, 1'b0);
    send(MODE_IGNORED, 16'hFFFF, 32'hFFFFFFFF, 1'b1);

    // Zero rate limit gives the widest spacing
    program_regs(1'b1, 16'd0, 16'd1, 16'hFFFF);
    send(asrp_pkg::MODE_START, 16'h1234, 32'd0, 1'b1);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd0, 1'b1);
    send(asrp_pkg::MODE_STOP, 16'd0, 32'd0, 1'b1);

    // Boundary wrapping past the top of the seconds count, zero samples at a boundary,
    // retry on a busy buffer, restart while running
    program_regs(1'b1, 16'hFFFF, 16'd1, 16'hFFFF);
    send(asrp_pkg::MODE_START, 16'hFFFF, 32'hFFFFFFF0, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'hFFFFFFF0, 1'b1);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'hFFFFFFF0, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd0, 1'b1);
    send(asrp_pkg::MODE_START, 16'd0, 32'd5, 1'b1);

    // Busy buffer with small spacing skips, with large spacing retries
    program_regs(1'b1, 16'hFFFF, 16'd200, 16'd300);
    send(asrp_pkg::MODE_START, 16'hFFFF, 32'd100, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd100, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd160, 1'b0);

    // Lower clamp above upper clamp: a spacing above both takes the upper one
    program_regs(1'b1, 16'hFFFF, 16'd300, 16'd200);
    send(asrp_pkg::MODE_START, 16'd61440, 32'd0, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd0, 1'b1);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd60, 1'b1);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd61, 1'b1);
    send(asrp_pkg::MODE_STOP, 16'd0, 32'd62, 1'b0);
    send(asrp_pkg::MODE_TICK, 16'd0, 32'd200, 1'b1);

    // Random sessions under a series of register settings; the last phase runs calm
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: program_regs(1'b1, 16'hFFFF, 16'd1, 16'hFFFF);
        1: program_regs(1'b1, 16'd1, 16'd1, 16'd40);
        2: program_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_regs(1'b1, asrp_pkg::MAX_RATE_RST, asrp_pkg::MIN_SPACE_RST,
                        asrp_pkg::MAX_SPACE_RST);
        4: program_regs(1'b0, 16'($urandom), 16'($urandom_range(1, 64)),
                        16'($urandom_range(1, 65535)));
        5: program_regs(1'b1, 16'd0, 16'($urandom_range(1, 64)),
                        16'($urandom_range(64, 65535)));
        default: program_regs(1'b1, 16'($urandom), 16'($urandom_range(1, 64)),
                              16'($urandom_range(1, 65535)));
      endcase
      steady <= (phase != 8) && ($urandom_range(0, 3) == 0);
      calm   <= (phase == 8);
      quota = words + ((phase == 4) ? 10 : 30);
      while (words < quota) session($urandom_range(8, 40));
    end

    drain_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hold a hard limit on the whole run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
